// File: hw/rtl/ufd_pkg.sv
`default_nettype none

package ufd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned FIELD_W      = 16;
    localparam int unsigned LIMIT_W      = 17;
    localparam int unsigned WIN_LEN      = 8;
    localparam int unsigned FILL_W       = 4;
    localparam int unsigned WIN_SUM_W    = 11;
    localparam int unsigned HEADER_BYTES = 10;
    localparam int unsigned BUFFER_BYTES = 1024;

    localparam logic [LIMIT_W-1:0] MAX_LEN_RESET = LIMIT_W'(BUFFER_BYTES);
    localparam logic [LIMIT_W-1:0] HEADER_LEN    = LIMIT_W'(HEADER_BYTES);
    localparam logic [FILL_W-1:0]  FILL_FULL     = FILL_W'(WIN_LEN);

    // Configuration register indexes.
    typedef enum logic {
        CFG_FRAME_FLAG    = 1'b0,
        CFG_MAX_FRAME_LEN = 1'b1
    } t_cfg_reg;

    // Deframer phase, one-hot.
    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_CHK_LO = 4'b0010,
        PH_CHK_HI = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    // Header check result for the window as it stands after the current byte.
    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] index;
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] sum;
    } t_hdr_info;

    // One body byte result.
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               is_type;
        logic               last;
        logic               status;
        logic [FIELD_W-1:0] frame_index;
        logic [FIELD_W-1:0] frame_total;
        logic [FIELD_W-1:0] sum_computed;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/ufd_hdr_window.sv
`default_nettype none

module ufd_hdr_window (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_shift,
    input  wire logic                         i_clear,
    input  wire logic [ufd_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [ufd_pkg::FIELD_W-1:0]  i_frame_flag,
    input  wire logic [ufd_pkg::LIMIT_W-1:0]  i_max_frame_len,
    output ufd_pkg::t_hdr_info                o_hdr,
    output logic      [ufd_pkg::FIELD_W-1:0]  o_cur_len
);
    import ufd_pkg::*;

    logic [BYTE_W-1:0]    r_win [WIN_LEN];
    logic [BYTE_W-1:0]    n_win [WIN_LEN];
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic [FIELD_W-1:0]   flag;
    logic [WIN_SUM_W-1:0] win_sum;
    logic                 ok;

    // Window as it looks once the incoming byte is shifted in.
    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            n_win[k] = r_win[k+1];
        end
        n_win[WIN_LEN-1] = i_byte;
        n_fill = (r_fill < FILL_FULL) ? r_fill + FILL_W'(1) : r_fill;
    end

    always_comb begin
        win_sum = '0;
        for (int k = 0; k < WIN_LEN; k++) begin
            win_sum = win_sum + WIN_SUM_W'(n_win[k]);
        end
    end

    assign flag        = {n_win[1], n_win[0]};
    assign o_hdr.len   = {n_win[3], n_win[2]};
    assign o_hdr.index = {n_win[5], n_win[4]};
    assign o_hdr.total = {n_win[7], n_win[6]};
    assign o_hdr.sum   = FIELD_W'(win_sum);

    assign ok = (flag == i_frame_flag) && (o_hdr.len != '0) &&
                (o_hdr.index < o_hdr.total) &&
                (HEADER_LEN + LIMIT_W'(o_hdr.len) <= i_max_frame_len);

    assign o_hdr.hit = (n_fill >= FILL_FULL) && ok;

    // The window holds still during a frame, so its length field is still valid.
    assign o_cur_len = {r_win[3], r_win[2]};

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
        end else if (i_shift) begin
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ufd_frame_ctrl.sv
`default_nettype none

module ufd_frame_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_take,
    input  wire logic [ufd_pkg::BYTE_W-1:0]   i_byte,
    input  wire ufd_pkg::t_hdr_info           i_hdr,
    input  wire logic [ufd_pkg::FIELD_W-1:0]  i_cur_len,
    output logic                              o_searching,
    output logic                              o_in_body,
    output logic                              o_frame_end,
    output logic                              o_res_valid,
    output ufd_pkg::t_result                  o_res
);
    import ufd_pkg::*;

    t_phase             r_phase;
    logic [FIELD_W-1:0] r_check;
    logic [FIELD_W-1:0] r_sum;
    logic [FIELD_W-1:0] r_left;
    logic [FIELD_W-1:0] r_index;
    logic [FIELD_W-1:0] r_total;
    logic [FIELD_W-1:0] sum_next;
    logic               fin;

    assign o_searching = (r_phase == PH_SEARCH);
    assign o_in_body   = (r_phase == PH_BODY);

    assign sum_next = r_sum + FIELD_W'(i_byte);
    assign fin      = (r_left == FIELD_W'(1));

    assign o_res_valid = i_take && o_in_body;
    assign o_frame_end = o_res_valid && fin;

    assign o_res.data_byte    = i_byte;
    assign o_res.is_type      = (r_left == i_cur_len);
    assign o_res.last         = fin;
    assign o_res.status       = fin && (sum_next != r_check);
    assign o_res.frame_index  = r_index;
    assign o_res.frame_total  = r_total;
    assign o_res.sum_computed = sum_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
        end else if (i_take) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (i_hdr.hit) begin
                        r_phase <= PH_CHK_LO;
                    end
                end
                PH_CHK_LO: r_phase <= PH_CHK_HI;
                PH_CHK_HI: r_phase <= PH_BODY;
                PH_BODY: begin
                    if (fin) begin
                        r_phase <= PH_SEARCH;
                    end
                end
                default:   r_phase <= PH_SEARCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (i_hdr.hit) begin
                        r_sum   <= i_hdr.sum;
                        r_left  <= i_hdr.len;
                        r_index <= i_hdr.index;
                        r_total <= i_hdr.total;
                    end
                end
                PH_CHK_LO: r_check[BYTE_W-1:0]       <= i_byte;
                PH_CHK_HI: r_check[FIELD_W-1:BYTE_W] <= i_byte;
                PH_BODY: begin
                    r_sum  <= sum_next;
                    r_left <= r_left - FIELD_W'(1);
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ufd_out_reg.sv
`default_nettype none

module ufd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire ufd_pkg::t_result  i_res,
    input  wire logic              i_ready,
    output logic                   o_space,
    output logic                   o_valid,
    output ufd_pkg::t_result       o_res
);
    import ufd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can take a new result when empty or being drained now.
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/uart_frame_deframer_checksum.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// rx        in         i_rx_valid / o_rx_ready    i_rx_byte
// out       out        o_out_valid / i_out_ready  o_data_byte, o_is_type, o_last, o_status,
//                                                 o_frame_index, o_frame_total, o_sum_computed
// cfg       in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// Bytes are handled in the cycle they are accepted, one per cycle unless a body byte must wait.
// A body byte loads the output register in that same cycle; it is shown on the next cycle.
// Reset is synchronous and active low; it returns the deframer to header search with an empty
// window and restores the register defaults. No clearing pass is needed.
// Header and checksum bytes are accepted even while a result waits; a body byte waits
// only when the output register is full and not being drained.

module uart_frame_deframer_checksum (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rx_valid,
    output logic                              o_rx_ready,
    input  wire logic [ufd_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [ufd_pkg::BYTE_W-1:0]   o_data_byte,
    output logic                              o_is_type,
    output logic                              o_last,
    output logic                              o_status,
    output logic      [ufd_pkg::FIELD_W-1:0]  o_frame_index,
    output logic      [ufd_pkg::FIELD_W-1:0]  o_frame_total,
    output logic      [ufd_pkg::FIELD_W-1:0]  o_sum_computed,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [ufd_pkg::LIMIT_W-1:0]  i_cfg_data
);
    import ufd_pkg::*;

    logic [FIELD_W-1:0] r_frame_flag;
    logic [LIMIT_W-1:0] r_max_frame_len;

    t_hdr_info          hdr;
    logic [FIELD_W-1:0] cur_len;
    logic               searching;
    logic               in_body;
    logic               frame_end;
    logic               res_valid;
    t_result            res;
    t_result            out_res;
    logic               out_space;
    logic               take;

    // Only a body byte produces a result, so only it needs room downstream.
    assign o_rx_ready = !in_body || out_space;
    assign take       = i_rx_valid && o_rx_ready;

    // Configuration registers; a write is applied at once and affects the next header check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_flag    <= '0;
            r_max_frame_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_FLAG:    r_frame_flag    <= i_cfg_data[FIELD_W-1:0];
                CFG_MAX_FRAME_LEN: r_max_frame_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The sliding header window and its validity check.
    ufd_hdr_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_shift         (take && searching),
        .i_clear         (frame_end),
        .i_byte          (i_rx_byte),
        .i_frame_flag    (r_frame_flag),
        .i_max_frame_len (r_max_frame_len),
        .o_hdr           (hdr),
        .o_cur_len       (cur_len)
    );

    // Phase sequencing, checksum capture, running sum and body byte count.
    ufd_frame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_rx_byte),
        .i_hdr       (hdr),
        .i_cur_len   (cur_len),
        .o_searching (searching),
        .o_in_body   (in_body),
        .o_frame_end (frame_end),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register that separates the two handshakes.
    ufd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_data_byte    = out_res.data_byte;
    assign o_is_type      = out_res.is_type;
    assign o_last         = out_res.last;
    assign o_status       = out_res.status;
    assign o_frame_index  = out_res.frame_index;
    assign o_frame_total  = out_res.frame_total;
    assign o_sum_computed = out_res.sum_computed;

endmodule

`default_nettype wire

// File: test/tb_uart_frame_deframer_checksum.sv
`default_nettype none

module tb_uart_frame_deframer_checksum;

    import ufd_pkg::*;

    // The longest stretch in which neither channel moves a request is a few sender or
    // receiver stall bursts plus a settle wait and a register write. This limit is far
    // above that, but it still ends a hung run quickly.
    localparam int WATCHDOG_LIMIT = 2000;

    // A received byte is handled in the cycle it is accepted, and its body result shows up
    // on the next cycle; this wait lets the block go quiet.
    localparam int SETTLE_CYCLES = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 rx_valid;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_ready;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;

    logic                 o_rx_ready;
    logic                 o_out_valid;
    logic [BYTE_W-1:0]    o_data_byte;
    logic                 o_is_type;
    logic                 o_last;
    logic                 o_status;
    logic [FIELD_W-1:0]   o_frame_index;
    logic [FIELD_W-1:0]   o_frame_total;
    logic [FIELD_W-1:0]   o_sum_computed;

    uart_frame_deframer_checksum u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_data_byte    (o_data_byte),
        .o_is_type      (o_is_type),
        .o_last         (o_last),
        .o_status       (o_status),
        .o_frame_index  (o_frame_index),
        .o_frame_total  (o_frame_total),
        .o_sum_computed (o_sum_computed),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------------------
    // Shadow copy of the deframer. It is advanced once per accepted byte and once per
    // register write, in the same order the block sees them, so its state always matches
    // the block's state at the same edge.
    // ------------------------------------------------------------------------------------
    logic [BYTE_W-1:0]  hdr_win [WIN_LEN];
    t_phase             deframe_phase;
    logic [FIELD_W-1:0] captured_sum;
    logic [FIELD_W-1:0] byte_sum;
    logic [FIELD_W-1:0] body_left;
    logic [FIELD_W-1:0] body_len;
    logic [FIELD_W-1:0] hdr_index;
    logic [FIELD_W-1:0] hdr_total;
    int                 win_count;
    logic [FIELD_W-1:0] start_flag;
    logic [LIMIT_W-1:0] frame_limit;

    // Body bytes the block still owes us, oldest first.
    t_result body_due [$];

    bit idle_on;
    int errors;
    int bytes_sent;
    int quiet_cycles;

    // A little-endian 16-bit field of the header window.
    function automatic logic [FIELD_W-1:0] win_word(input int pos);
        return {hdr_win[pos+1], hdr_win[pos]};
    endfunction

    // The window holds a header worth acting on: right flag, some body, an index below the
    // total, and a whole frame that fits the current limit.
    function automatic bit header_valid();
        logic [FIELD_W-1:0] len;
        len = win_word(2);
        return (win_word(0) == start_flag) && (len != '0) && (win_word(4) < win_word(6))
            && (int'(len) + int'(HEADER_BYTES) <= int'(frame_limit));
    endfunction

    // Advances the shadow deframer by one received byte and queues the body byte result
    // that it causes, if any.
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        t_result            res;
        logic [FIELD_W-1:0] s;
        case (deframe_phase)
            PH_SEARCH: begin
                // Slide the window by one; a header is only checked once it is full.
                for (int k = 0; k < WIN_LEN - 1; k++) hdr_win[k] = hdr_win[k+1];
                hdr_win[WIN_LEN-1] = b;
                if (win_count < WIN_LEN) win_count++;
                if (win_count == WIN_LEN && header_valid()) begin
                    s = '0;
                    foreach (hdr_win[k]) s += FIELD_W'(hdr_win[k]);
                    byte_sum      = s;
                    body_len      = win_word(2);
                    body_left     = body_len;
                    hdr_index     = win_word(4);
                    hdr_total     = win_word(6);
                    deframe_phase = PH_CHK_LO;
                end
            end
            PH_CHK_LO: begin
                captured_sum  = {8'h00, b};
                deframe_phase = PH_CHK_HI;
            end
            PH_CHK_HI: begin
                captured_sum[15:8] = b;
                deframe_phase      = PH_BODY;
            end
            default: begin
                res.is_type      = (body_left == body_len);
                byte_sum         = byte_sum + FIELD_W'(b);
                body_left        = body_left - 1'b1;
                res.data_byte    = b;
                res.last         = (body_left == '0);
                res.status       = res.last && (byte_sum != captured_sum);
                res.frame_index  = hdr_index;
                res.frame_total  = hdr_total;
                res.sum_computed = byte_sum;
                body_due.push_back(res);
                if (res.last) begin
                    // The next frame is searched for with an empty window.
                    deframe_phase = PH_SEARCH;
                    win_count     = 0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Clock, reset and the quiet-time watchdog.
    // ------------------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog restarts whenever either channel moves a request. If nothing moves for
    // too long, the block has hung and the run ends as a failure.
    always @(posedge i_clk) begin
        if ((rx_valid && o_rx_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Result side. The receiver drops ready in random bursts while idling is on. Every
    // accepted body byte is compared field by field with the oldest queued prediction.
    // ------------------------------------------------------------------------------------
    initial begin
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_ready = 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready = 1'b0;
                stall     = $urandom_range(0, 7);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : check_body
        t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (body_due.size() == 0) begin
                $error("body byte %0h arrived with nothing outstanding", o_data_byte);
                errors++;
            end else begin
                want = body_due.pop_front();
                check_field("data_byte", FIELD_W'(want.data_byte), FIELD_W'(o_data_byte));
                check_field("is_type", FIELD_W'(want.is_type), FIELD_W'(o_is_type));
                check_field("last", FIELD_W'(want.last), FIELD_W'(o_last));
                check_field("status", FIELD_W'(want.status), FIELD_W'(o_status));
                check_field("frame_index", want.frame_index, o_frame_index);
                check_field("frame_total", want.frame_total, o_frame_total);
                check_field("sum_computed", want.sum_computed, o_sum_computed);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus helpers. Inputs change only at the falling edge; the accept is seen at the
    // rising edge, where the shadow deframer is advanced.
    // ------------------------------------------------------------------------------------

    // Sends one byte as an rx request. While idling is on, valid drops for a random burst
    // now and then before the byte is offered. Valid stays high from one byte to the next.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        rx_valid = 1'b1;
        rx_byte  = b;
        do @(posedge i_clk); while (!o_rx_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Stops sending and waits until every predicted body byte has come out, then lets the
    // block settle, since header and checksum bytes leave no result behind.
    task automatic drain();
        @(negedge i_clk);
        rx_valid = 1'b0;
        while (body_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [LIMIT_W-1:0] val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge i_clk);
        if (idx == CFG_FRAME_FLAG) begin
            start_flag = val[FIELD_W-1:0];
        end else begin
            frame_limit = val;
        end
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Sends a frame: the 8 header bytes, the checksum and body_n body bytes. The checksum
    // is right unless bad_sum is set. A body byte of -1 means random body bytes. With
    // pause_mid set, the sender stops halfway through the body until every result is in,
    // and the limit is shrunk to the smallest one; the frame already under way must not
    // notice.
    task automatic send_frame(input logic [FIELD_W-1:0] flag, input logic [FIELD_W-1:0] len,
                              input logic [FIELD_W-1:0] index,
                              input logic [FIELD_W-1:0] total, input int body_n,
                              input bit bad_sum, input int body_byte = -1,
                              input bit pause_mid = 1'b0);
        logic [63:0]        hdr;
        logic [BYTE_W-1:0]  body [$];
        logic [FIELD_W-1:0] s;
        hdr = {total, index, len, flag};
        s   = '0;
        for (int k = 0; k < WIN_LEN; k++) s += FIELD_W'(hdr[8*k +: 8]);
        for (int k = 0; k < body_n; k++) begin
            body.push_back(body_byte < 0 ? BYTE_W'($urandom) : BYTE_W'(body_byte));
        end
        foreach (body[k]) s += FIELD_W'(body[k]);
        if (bad_sum) s ^= FIELD_W'($urandom_range(1, 65535));
        for (int k = 0; k < WIN_LEN; k++) send_byte(hdr[8*k +: 8]);
        send_byte(s[7:0]);
        send_byte(s[15:8]);
        foreach (body[k]) begin
            if (pause_mid && k == body.size() / 2) begin
                drain();
                write_reg(CFG_MAX_FRAME_LEN, LIMIT_W'(HEADER_BYTES + 1));
            end
            send_byte(body[k]);
        end
    endtask

    // One piece of random traffic, mostly well-formed frames with random content under the
    // current settings, the rest broken headers, bad checksums and line noise.
    task automatic send_random_frame();
        int                 kind;
        int                 pick;
        int                 max_body;
        int                 cap;
        int                 low;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] idx;
        logic [FIELD_W-1:0] tot;
        max_body = int'(frame_limit) - int'(HEADER_BYTES);
        if (max_body > 65535) max_body = 65535;
        tot = FIELD_W'($urandom_range(1, 65535));
        idx = FIELD_W'($urandom_range(0, int'(tot) - 1));
        // Most frames are short; a few are long enough to cross many stall bursts.
        pick = $urandom_range(0, 99);
        cap  = (pick < 80) ? 16 : (pick < 95) ? 64 : 200;
        if (cap > max_body) cap = max_body;
        len  = (cap < 1) ? 16'd1 : FIELD_W'($urandom_range(1, cap));
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            send_frame(start_flag, len, idx, tot, int'(len), 1'b0);
        end else if (kind < 80) begin
            send_frame(start_flag, len, idx, tot, int'(len), 1'b1);
        end else if (kind < 85) begin
            // Wrong flag: the window just slides over the whole thing.
            send_frame(start_flag ^ FIELD_W'($urandom_range(1, 65535)), len, idx, tot,
                       int'(len), 1'b0);
        end else if (kind < 88) begin
            send_frame(start_flag, '0, idx, tot, $urandom_range(0, 8), 1'b0);
        end else if (kind < 92) begin
            // Index at or past the total.
            tot = FIELD_W'($urandom_range(0, 65535));
            idx = FIELD_W'($urandom_range(int'(tot), 65535));
            send_frame(start_flag, len, idx, tot, $urandom_range(0, 8), 1'b0);
        end else if (kind < 95 && max_body < 65535) begin
            // Length one past what the limit admits, or anything beyond.
            low = (max_body < 0) ? 1 : max_body + 1;
            len = ($urandom_range(0, 1) == 0) ? FIELD_W'(low) : FIELD_W'($urandom_range(low, 65535));
            send_frame(start_flag, len, idx, tot, $urandom_range(0, 8), 1'b0);
        end else begin
            repeat ($urandom_range(1, 12)) send_byte(BYTE_W'($urandom));
        end
    endtask

    task automatic run_traffic(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) send_random_frame();
        drain();
    endtask

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // With the reset settings the flag is zero and the limit is the buffer size, so the
    // smallest frame, all zero but for its length and total, goes through.
    task automatic test_reset_defaults();
        send_frame(16'h0000, 16'd1, 16'h0000, 16'h0001, 1, 1'b0, 8'h00);
        drain();
    endtask

    // All-ones flag and the smallest limit that admits a frame. A one-byte frame fits
    // exactly and carries a bad checksum, so the body still comes out but is flagged. A
    // two-byte frame is one byte too long and is skipped.
    task automatic test_extremes_and_mismatch();
        write_reg(CFG_FRAME_FLAG, LIMIT_W'(16'hFFFF));
        write_reg(CFG_MAX_FRAME_LEN, LIMIT_W'(HEADER_BYTES + 1));
        send_frame(16'hFFFF, 16'd1, 16'hFFFE, 16'hFFFF, 1, 1'b1, 8'hFF);
        send_frame(16'hFFFF, 16'd2, 16'h0000, 16'h0001, 0, 1'b0);
        drain();
    endtask

    // Broken headers are slid over without a result, and a good frame still gets found
    // right after them.
    task automatic test_header_rejects();
        write_reg(CFG_FRAME_FLAG, LIMIT_W'(16'h5AA5));
        write_reg(CFG_MAX_FRAME_LEN, MAX_LEN_RESET);
        send_frame(16'h5AA5, 16'd0, 16'd0, 16'd1, 0, 1'b0);
        send_frame(16'h5AA5, 16'd1, 16'd7, 16'd7, 0, 1'b0);
        send_frame(16'hA55A, 16'd1, 16'd0, 16'd1, 0, 1'b0);
        send_frame(16'h5AA5, 16'd3, 16'd0, 16'd1, 3, 1'b0);
        drain();
    endtask

    // A limit below the smallest frame admits nothing; the block keeps searching.
    task automatic test_small_limit();
        write_reg(CFG_MAX_FRAME_LEN, LIMIT_W'(HEADER_BYTES));
        send_frame(16'h5AA5, 16'd1, 16'd0, 16'd1, 1, 1'b0);
        drain();
        write_reg(CFG_MAX_FRAME_LEN, '0);
        send_frame(16'h5AA5, 16'd1, 16'd0, 16'd1, 1, 1'b0);
        drain();
    endtask

    // The sender stops in the middle of a body until every result is in; the limit then
    // shrinks below this frame's size, which must not cut the frame short.
    task automatic test_pause_mid_frame();
        write_reg(CFG_MAX_FRAME_LEN, MAX_LEN_RESET);
        send_frame(16'h5AA5, 16'd6, 16'h1234, 16'h4321, 6, 1'b0, -1, 1'b1);
        drain();
    endtask

    // Random traffic under several settings, with stalls on both sides. The limit walks
    // through its largest useful value, its smallest useful value and values in between.
    task automatic test_random_traffic();
        logic [LIMIT_W-1:0] limits [5];
        limits[0] = 17'd65545;
        limits[1] = LIMIT_W'(HEADER_BYTES + 1);
        limits[2] = LIMIT_W'($urandom_range(12, 300));
        limits[3] = MAX_LEN_RESET;
        limits[4] = LIMIT_W'($urandom_range(11, 65545));
        foreach (limits[k]) begin
            write_reg(CFG_FRAME_FLAG, LIMIT_W'($urandom_range(0, 65535)));
            write_reg(CFG_MAX_FRAME_LEN, limits[k]);
            run_traffic(280);
        end
    endtask

    // The last stretch runs with no idling on either side, so bytes and results move at
    // full rate.
    task automatic test_full_rate();
        idle_on = 1'b0;
        write_reg(CFG_FRAME_FLAG, LIMIT_W'($urandom_range(0, 65535)));
        write_reg(CFG_MAX_FRAME_LEN, MAX_LEN_RESET);
        run_traffic(250);
    endtask

    // ------------------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        rx_valid      = 1'b0;
        rx_byte       = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FRAME_FLAG;
        cfg_data      = '0;
        idle_on       = 1'b1;
        errors        = 0;
        bytes_sent    = 0;
        quiet_cycles  = 0;
        foreach (hdr_win[k]) hdr_win[k] = '0;
        deframe_phase = PH_SEARCH;
        captured_sum  = '0;
        byte_sum      = '0;
        body_left     = '0;
        body_len      = '0;
        hdr_index     = '0;
        hdr_total     = '0;
        win_count     = 0;
        start_flag    = '0;
        frame_limit   = MAX_LEN_RESET;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_extremes_and_mismatch();
        test_header_rejects();
        test_small_limit();
        test_pause_mid_frame();
        test_random_traffic();
        test_full_rate();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/ufd_pkg.sv
hw/rtl/ufd_hdr_window.sv
hw/rtl/ufd_frame_ctrl.sv
hw/rtl/ufd_out_reg.sv
hw/rtl/uart_frame_deframer_checksum.sv
test/tb_uart_frame_deframer_checksum.sv
